[rtl/atatfi_pkg.sv]
`timescale 1ns / 1ps

package atatfi_pkg;

  localparam int unsigned IDENTIFY_BYTES = 512;
  localparam int unsigned DRIVE_COUNT    = 2;
  localparam int unsigned POS_W          = $clog2(IDENTIFY_BYTES);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE0_PRESENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE1_PRESENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE0_SECTORS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE1_SECTORS = 3'd5;

  localparam logic [15:0] COMMAND_BASE_RST = 16'h01F0;
  localparam logic [15:0] CONTROL_BASE_RST = 16'h03F6;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] CMD_SPAN = 4'hD;

  localparam logic [2:0] REG_DATA      = 3'd0;
  localparam logic [2:0] REG_FEAT_ERR  = 3'd1;
  localparam logic [2:0] REG_SEC_COUNT = 3'd2;
  localparam logic [2:0] REG_SEC_NUM   = 3'd3;
  localparam logic [2:0] REG_CYL_LOW   = 3'd4;
  localparam logic [2:0] REG_CYL_HIGH  = 3'd5;
  localparam logic [2:0] REG_DRV_HEAD  = 3'd6;
  localparam logic [2:0] REG_CMD_STAT  = 3'd7;

  localparam logic [7:0] CMD_IDENTIFY    = 8'hEC;
  localparam logic [7:0] CMD_INIT_PARAMS = 8'h91;
  localparam logic [7:0] ERR_ABORT       = 8'h04;

  localparam logic [7:0] ST_BUSY  = 8'h80;
  localparam logic [7:0] ST_READY = 8'h40;
  localparam logic [7:0] ST_DRQ   = 8'h08;
  localparam logic [7:0] ST_ERR   = 8'h01;

  localparam logic [3:0] DCTL_MASK = 4'hF;
  localparam logic [6:0] DSEL_MASK = 7'h7F;

  localparam logic [15:0] ID_GENERAL_CFG = 16'h0042;
  localparam logic [15:0] ID_HEADS       = 16'd16;
  localparam logic [15:0] ID_SEC_PER_TRK = 16'd63;
  localparam logic [15:0] ID_CAPS        = 16'h0200;
  localparam logic [15:0] ID_CMD_SET     = 16'h1000;
  localparam logic [15:0] ID_ONE         = 16'd1;
  localparam logic [15:0] CYL_MAX        = 16'hFFFF;

  // Cylinders are sectors / 1008: sectors / 16 by shift, then / 63 by reciprocal.
  localparam int unsigned DIV_X_W    = 24;
  localparam int unsigned DIV_SHIFT  = 30;
  localparam int unsigned DIV_M_W    = 25;
  localparam logic [DIV_M_W-1:0] DIV_M = 25'd17043521;
  localparam int unsigned DIV_Q_W    = 19;
  localparam logic [DIV_X_W-1:0] DIV_D = 24'd63;

  typedef enum logic [2:0] {
    XS_READY  = 3'b001,
    XS_ERROR  = 3'b010,
    XS_RESULT = 3'b100
  } xfer_state_t;

  typedef struct packed {
    logic [7:0] features;
    logic [7:0] sec_count;
    logic [7:0] sec_num;
    logic [7:0] cyl_low;
    logic [7:0] cyl_high;
    logic [7:0] drv_head;
    logic [7:0] error;
    logic [7:0] status;
  } task_file_t;

  function automatic logic [7:0] ident_byte(input logic [POS_W-1:0] pos,
                                            input logic present,
                                            input logic [15:0] cyl,
                                            input logic [27:0] sectors,
                                            input logic drive);
    logic [15:0] w;
    w = '0;
    if (present) begin
      case (pos[POS_W-1:1])
        8'd0:        w = ID_GENERAL_CFG;
        8'd1, 8'd54: w = cyl;
        8'd2, 8'd55: w = ID_HEADS;
        8'd6, 8'd56: w = ID_SEC_PER_TRK;
        8'd21:       w = ID_ONE;
        8'd49:       w = ID_CAPS;
        8'd60:       w = sectors[15:0];
        8'd61:       w = {4'd0, sectors[27:16]};
        8'd93:       w = drive ? 16'd0 : ID_CMD_SET;
        default:     w = '0;
      endcase
    end
    return pos[0] ? w[15:8] : w[7:0];
  endfunction

endpackage

[rtl/atatfi_req_if.sv]
`timescale 1ns / 1ps

interface atatfi_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] port_address;
  logic [7:0]  write_data;

  modport source (output valid, opcode, port_address, write_data, input ready);
  modport sink (input valid, opcode, port_address, write_data, output ready);
endinterface

[rtl/atatfi_rsp_if.sv]
`timescale 1ns / 1ps

interface atatfi_rsp_if;
  logic       valid;
  logic       ready;
  logic       claimed;
  logic [7:0] read_data;
  logic       irq_raise;

  modport source (output valid, claimed, read_data, irq_raise, input ready);
  modport sink (input valid, claimed, read_data, irq_raise, output ready);
endinterface

[rtl/ata_task_file_identify_unit.sv]
`timescale 1ns / 1ps

// An accepted request is held in the s1 input register and its response in the output register.
// Throughput: one request per cycle while the response side keeps ready high.
// The identify cylinder value is computed in a two-stage divider behind the command write.
// Reset (rst_n low, synchronous) clears all task-file and control registers and returns
// the configuration to the default port bases with both drives absent.
module ata_task_file_identify_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [atatfi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [atatfi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  atatfi_req_if.sink                          in_req,
  atatfi_rsp_if.source                        out_rsp
);
  import atatfi_pkg::*;

  logic [15:0] cmd_base_r, ctl_base_r;
  logic        present_r [DRIVE_COUNT];
  logic [27:0] sectors_r [DRIVE_COUNT];

  logic        s1_valid_r, s1_op_r;
  logic [15:0] s1_port_r;
  logic [7:0]  s1_wdata_r;
  logic        adv;

  logic       out_valid_r, out_claimed_r, out_irq_r;
  logic [7:0] out_rdata_r;

  task_file_t  tf_r [DRIVE_COUNT];
  task_file_t  tf_nxt [DRIVE_COUNT];
  logic        active_r, active_nxt;
  xfer_state_t xs_r, xs_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic        id_drive_r, id_drive_nxt;
  logic        id_present_r, id_present_nxt;
  logic [27:0] id_sec_r, id_sec_nxt;
  logic [3:0]  dctl_r, dctl_nxt;
  logic [6:0]  dsel_r, dsel_nxt;

  logic [DIV_X_W-1:0] div_x_r;
  logic [DIV_Q_W-1:0] div_q0_r;
  logic [DIV_X_W+DIV_M_W-1:0] div_prod;
  logic [DIV_X_W-1:0] div_rem;
  logic [DIV_Q_W-1:0] div_q;
  logic [15:0] cyl_r;

  logic [16:0] cmd_diff, ctl_diff;
  logic        cmd_hit, ctl_hit;
  logic [3:0]  cmd_ofs;
  logic        d;
  logic        claimed_c, irq_c;
  logic [7:0]  rdata_c;
  logic [7:0]  stat_c;

  assign adv          = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || adv;

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.claimed   = out_claimed_r;
  assign out_rsp.read_data = out_rdata_r;
  assign out_rsp.irq_raise = out_irq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_base_r   <= COMMAND_BASE_RST;
      ctl_base_r   <= CONTROL_BASE_RST;
      present_r[0] <= 1'b0;
      present_r[1] <= 1'b0;
      sectors_r[0] <= '0;
      sectors_r[1] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMMAND_BASE:   cmd_base_r   <= cfg_wdata[15:0];
        CFG_CONTROL_BASE:   ctl_base_r   <= cfg_wdata[15:0];
        CFG_DRIVE0_PRESENT: present_r[0] <= cfg_wdata[0];
        CFG_DRIVE1_PRESENT: present_r[1] <= cfg_wdata[0];
        CFG_DRIVE0_SECTORS: sectors_r[0] <= cfg_wdata;
        CFG_DRIVE1_SECTORS: sectors_r[1] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.valid && in_req.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_op_r    <= in_req.opcode;
      s1_port_r  <= in_req.port_address;
      s1_wdata_r <= in_req.write_data;
    end
  end

  assign cmd_diff = {1'b0, s1_port_r} - {1'b0, cmd_base_r};
  assign ctl_diff = {1'b0, s1_port_r} - {1'b0, ctl_base_r};
  assign cmd_hit  = !cmd_diff[16] && (cmd_diff[15:4] == '0) && (cmd_diff[3:0] <= CMD_SPAN);
  assign ctl_hit  = !ctl_diff[16] && (ctl_diff[15:1] == '0);
  assign cmd_ofs  = cmd_diff[3:0];
  assign d        = active_r;

  always_comb begin
    stat_c = (tf_r[d].status & ~(ST_BUSY | ST_DRQ)) | ST_READY;
    if (xs_r != XS_READY) stat_c = stat_c | ST_DRQ;
    if (xs_r == XS_ERROR) stat_c = stat_c | ST_ERR;
  end

  always_comb begin
    tf_nxt         = tf_r;
    active_nxt     = active_r;
    xs_nxt         = xs_r;
    pos_nxt        = pos_r;
    id_drive_nxt   = id_drive_r;
    id_present_nxt = id_present_r;
    id_sec_nxt     = id_sec_r;
    dctl_nxt       = dctl_r;
    dsel_nxt       = dsel_r;
    claimed_c      = 1'b0;
    rdata_c        = '0;
    irq_c          = 1'b0;
    if (adv) begin
      if (cmd_hit) begin
        if (s1_op_r == OP_WRITE) begin
          claimed_c = 1'b1;
          case (cmd_ofs[2:0])
            REG_DATA: ;
            REG_FEAT_ERR:  tf_nxt[d].features  = s1_wdata_r;
            REG_SEC_COUNT: tf_nxt[d].sec_count = s1_wdata_r;
            REG_SEC_NUM:   tf_nxt[d].sec_num   = s1_wdata_r;
            REG_CYL_LOW:   tf_nxt[d].cyl_low   = s1_wdata_r;
            REG_CYL_HIGH:  tf_nxt[d].cyl_high  = s1_wdata_r;
            REG_DRV_HEAD: begin
              active_nxt = s1_wdata_r[4];
              tf_nxt[s1_wdata_r[4]].drv_head = s1_wdata_r;
            end
            REG_CMD_STAT: begin
              if (s1_wdata_r == CMD_INIT_PARAMS) begin
                xs_nxt          = XS_READY;
                tf_nxt[d].error = '0;
              end else if (s1_wdata_r == CMD_IDENTIFY) begin
                id_drive_nxt       = d;
                id_present_nxt     = present_r[d];
                id_sec_nxt         = sectors_r[d];
                tf_nxt[d].status   = '0;
                tf_nxt[d].error    = '0;
                tf_nxt[d].cyl_low  = '0;
                tf_nxt[d].cyl_high = '0;
                pos_nxt            = '0;
                xs_nxt             = XS_RESULT;
                irq_c              = 1'b1;
              end else begin
                tf_nxt[d].error = ERR_ABORT;
                xs_nxt          = XS_ERROR;
              end
            end
            default: ;
          endcase
        end else if (!cmd_ofs[3]) begin
          claimed_c = 1'b1;
          case (cmd_ofs[2:0])
            REG_DATA: begin
              if (xs_r == XS_RESULT) begin
                rdata_c = ident_byte(pos_r, id_present_r, cyl_r, id_sec_r, id_drive_r);
                pos_nxt = pos_r + 1'b1;
                if (pos_r == POS_W'(IDENTIFY_BYTES - 1)) xs_nxt = XS_READY;
              end
            end
            REG_FEAT_ERR:  rdata_c = tf_r[d].error;
            REG_SEC_COUNT: rdata_c = tf_r[d].sec_count;
            REG_SEC_NUM:   rdata_c = tf_r[d].sec_num;
            REG_CYL_LOW:   rdata_c = tf_r[d].cyl_low;
            REG_CYL_HIGH:  rdata_c = tf_r[d].cyl_high;
            REG_DRV_HEAD:  rdata_c = tf_r[d].drv_head;
            REG_CMD_STAT: begin
              rdata_c          = stat_c;
              tf_nxt[d].status = stat_c;
            end
            default: ;
          endcase
        end
      end else if (ctl_hit) begin
        claimed_c = 1'b1;
        if (s1_op_r == OP_WRITE) begin
          if (!ctl_diff[0]) dctl_nxt = s1_wdata_r[3:0] & DCTL_MASK;
          else dsel_nxt = s1_wdata_r[6:0] & DSEL_MASK;
        end else begin
          rdata_c = ctl_diff[0] ? {1'b0, dsel_r} : {4'd0, dctl_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r[0]      <= '0;
      tf_r[1]      <= '0;
      active_r     <= 1'b0;
      xs_r         <= XS_READY;
      pos_r        <= '0;
      id_drive_r   <= 1'b0;
      id_present_r <= 1'b0;
      id_sec_r     <= '0;
      dctl_r       <= '0;
      dsel_r       <= '0;
    end else begin
      tf_r         <= tf_nxt;
      active_r     <= active_nxt;
      xs_r         <= xs_nxt;
      pos_r        <= pos_nxt;
      id_drive_r   <= id_drive_nxt;
      id_present_r <= id_present_nxt;
      id_sec_r     <= id_sec_nxt;
      dctl_r       <= dctl_nxt;
      dsel_r       <= dsel_nxt;
    end
  end

  // The cylinder count follows the frozen capacity through div_x_r/div_q0_r and then cyl_r; the first data
  // read that needs it comes no earlier than the third read after the command.
  assign div_prod = {{DIV_M_W{1'b0}}, id_sec_r[27:4]} * {{DIV_X_W{1'b0}}, DIV_M};
  assign div_rem  = div_x_r - (DIV_X_W'(div_q0_r) * DIV_D);
  assign div_q    = div_q0_r + DIV_Q_W'(div_rem >= DIV_D);

  always_ff @(posedge clk) begin
    div_x_r  <= id_sec_r[27:4];
    div_q0_r <= div_prod[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT];
    cyl_r    <= (div_q > DIV_Q_W'(CYL_MAX)) ? CYL_MAX : div_q[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_claimed_r <= claimed_c;
      out_rdata_r   <= (s1_op_r == OP_WRITE) ? 8'd0 : rdata_c;
      out_irq_r     <= irq_c;
    end
  end

  a_irq_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_irq_r |-> out_claimed_r)
    else $error("irq raised on an unclaimed request");

  a_rdata_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rdata_r != 8'd0) |-> out_claimed_r)
    else $error("nonzero read data on an unclaimed request");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed request did not reach the output register");

  a_identify_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv && irq_c |=> (xs_r == XS_RESULT) && (pos_r == '0))
    else $error("identify command did not start the result transfer");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_port_r))
    else $error("stalled input register lost its request");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import atatfi_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       claimed;
    logic [7:0] read_data;
    logic       irq_raise;
  } rsp_item_t;

  typedef struct {
    logic        op;
    logic [15:0] port;
    logic [7:0]  wd;
    bit          typed;
    rsp_item_t   rsp;
  } bringup_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  atatfi_req_if req_if ();
  atatfi_rsp_if rsp_if ();

  ata_task_file_identify_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_rsp   (rsp_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the task file, the identify snapshot and the decode settings.
  logic [15:0] cmd_base, ctl_base;
  logic [1:0]  drv_present;
  logic [27:0] drv_sectors [2];
  task_file_t  tf [2];
  logic        act_drive;
  logic [7:0]  cur_cmd;
  xfer_state_t xstate;
  int unsigned id_pos;
  logic        id_drive, id_present;
  logic [27:0] id_sectors;
  logic [3:0]  dctl;
  logic [6:0]  dsel;

  rsp_item_t    pending_responses [$];
  bringup_row_t bringup [25];
  bit           idle_on;
  int           mismatches, n_reqs, n_rsps, n_identify, n_id_bytes, n_aborts, n_settings;

  function automatic rsp_item_t predict_access(input logic op, input logic [15:0] port,
                                               input logic [7:0] wd);
    rsp_item_t   r;
    int          coff, loff;
    logic [2:0]  sel;
    logic        d;
    logic [7:0]  s;
    logic [15:0] w;
    logic [27:0] cyl;
    r = '0;
    d = act_drive;
    coff = int'(port) - int'(cmd_base);
    loff = int'(port) - int'(ctl_base);
    sel = coff[2:0];
    if (coff >= 0 && coff <= int'(CMD_SPAN)) begin
      if (op == OP_WRITE) begin
        r.claimed = 1'b1;
        case (sel)
          REG_FEAT_ERR:  tf[d].features  = wd;
          REG_SEC_COUNT: tf[d].sec_count = wd;
          REG_SEC_NUM:   tf[d].sec_num   = wd;
          REG_CYL_LOW:   tf[d].cyl_low   = wd;
          REG_CYL_HIGH:  tf[d].cyl_high  = wd;
          REG_DRV_HEAD: begin
            act_drive = wd[4];
            tf[wd[4]].drv_head = wd;
          end
          REG_CMD_STAT: begin
            if (wd == CMD_INIT_PARAMS) begin
              xstate = XS_READY;
              tf[d].error = '0;
            end else if (wd == CMD_IDENTIFY) begin
              cur_cmd = CMD_IDENTIFY;
              id_drive = d;
              id_present = drv_present[d];
              id_sectors = drv_sectors[d];
              tf[d].status = '0;
              tf[d].error = '0;
              tf[d].cyl_low = '0;
              tf[d].cyl_high = '0;
              id_pos = 0;
              xstate = XS_RESULT;
              r.irq_raise = 1'b1;
              n_identify++;
            end else begin
              cur_cmd = '0;
              tf[d].error = ERR_ABORT;
              xstate = XS_ERROR;
              n_aborts++;
            end
          end
          default: ;
        endcase
      end else if (coff <= 7) begin
        r.claimed = 1'b1;
        case (sel)
          REG_DATA: begin
            if (xstate == XS_RESULT && cur_cmd == CMD_IDENTIFY) begin
              cyl = id_sectors / 28'd1008;
              if (cyl > 28'(CYL_MAX)) cyl = 28'(CYL_MAX);
              w = '0;
              if (id_present) begin
                case (id_pos >> 1)
                  0:       w = ID_GENERAL_CFG;
                  1, 54:   w = cyl[15:0];
                  2, 55:   w = ID_HEADS;
                  6, 56:   w = ID_SEC_PER_TRK;
                  21:      w = ID_ONE;
                  49:      w = ID_CAPS;
                  60:      w = id_sectors[15:0];
                  61:      w = {4'd0, id_sectors[27:16]};
                  93:      w = id_drive ? 16'h0000 : ID_CMD_SET;
                  default: w = '0;
                endcase
              end
              r.read_data = id_pos[0] ? w[15:8] : w[7:0];
              n_id_bytes++;
              id_pos++;
              if (id_pos >= IDENTIFY_BYTES) begin
                xstate = XS_READY;
                id_pos = 0;
              end
            end
          end
          REG_FEAT_ERR:  r.read_data = tf[d].error;
          REG_SEC_COUNT: r.read_data = tf[d].sec_count;
          REG_SEC_NUM:   r.read_data = tf[d].sec_num;
          REG_CYL_LOW:   r.read_data = tf[d].cyl_low;
          REG_CYL_HIGH:  r.read_data = tf[d].cyl_high;
          REG_DRV_HEAD:  r.read_data = tf[d].drv_head;
          default: begin
            s = (tf[d].status & ~(ST_BUSY | ST_DRQ)) | ST_READY;
            if (xstate != XS_READY) s = s | ST_DRQ;
            if (xstate == XS_ERROR) s = s | ST_ERR;
            tf[d].status = s;
            r.read_data = s;
          end
        endcase
      end
    end else if (loff >= 0 && loff <= 1) begin
      r.claimed = 1'b1;
      if (op == OP_WRITE) begin
        if (loff == 0) dctl = wd[3:0] & DCTL_MASK;
        else dsel = wd[6:0] & DSEL_MASK;
      end else begin
        r.read_data = (loff == 0) ? {4'd0, dctl} : {1'b0, dsel};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_req(input logic op, input logic [15:0] port, input logic [7:0] wd,
                          input bit use_typed = 1'b0, input rsp_item_t typed_rsp = '0);
    rsp_item_t want;
    int        gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.port_address <= port;
    req_if.write_data   <= wd;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    want = predict_access(op, port, wd);
    if (use_typed) want = typed_rsp;
    pending_responses.push_back(want);
    n_reqs++;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COMMAND_BASE:   cmd_base = val[15:0];
      CFG_CONTROL_BASE:   ctl_base = val[15:0];
      CFG_DRIVE0_PRESENT: drv_present[0] = val[0];
      CFG_DRIVE1_PRESENT: drv_present[1] = val[0];
      CFG_DRIVE0_SECTORS: drv_sectors[0] = val;
      CFG_DRIVE1_SECTORS: drv_sectors[1] = val;
      default: ;
    endcase
  endtask

  // Mostly identify runs and abort/recover pairs; the rest is scattered traffic.
  task automatic run_traffic(input int budget, input bit full_stream, input bit calm);
    int          done, kind, n;
    logic        op;
    logic [15:0] port;
    logic [7:0]  wd;
    done = 0;
    while (done < budget) begin
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      kind = full_stream ? 0 : $urandom_range(0, 9);
      if (kind < 5) begin
        n = full_stream ? IDENTIFY_BYTES : $urandom_range(1, 48);
        full_stream = 1'b0;
        send_req(OP_WRITE, cmd_base + 16'(REG_DRV_HEAD), 8'($urandom));
        send_req(OP_WRITE, cmd_base + 16'(REG_CYL_LOW), 8'($urandom));
        send_req(OP_WRITE, cmd_base + 16'(REG_CMD_STAT), CMD_IDENTIFY);
        send_req(OP_READ, cmd_base + 16'(REG_CMD_STAT), 8'($urandom));
        send_req(OP_READ, cmd_base + 16'(REG_CYL_LOW), 8'($urandom));
        repeat (n) send_req(OP_READ, cmd_base + 16'(REG_DATA), 8'($urandom));
        send_req(OP_READ, cmd_base + 16'(REG_CMD_STAT), 8'($urandom));
        done += n + 6;
      end else if (kind < 7) begin
        send_req(OP_WRITE, cmd_base + 16'(REG_CMD_STAT), 8'($urandom));
        send_req(OP_READ, cmd_base + 16'(REG_FEAT_ERR), 8'($urandom));
        send_req(OP_READ, cmd_base + 16'(REG_CMD_STAT), 8'($urandom));
        send_req(OP_WRITE, cmd_base + 16'(REG_CMD_STAT), CMD_INIT_PARAMS);
        send_req(OP_READ, cmd_base + 16'(REG_CMD_STAT), 8'($urandom));
        done += 5;
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          op = 1'($urandom);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: port = cmd_base + 16'($urandom_range(0, 13));
            6, 7:             port = ctl_base + 16'($urandom_range(0, 1));
            8: begin
              case ($urandom_range(0, 3))
                0:       port = cmd_base - 16'd1;
                1:       port = cmd_base + 16'd14;
                2:       port = ctl_base - 16'd1;
                default: port = ctl_base + 16'd2;
              endcase
            end
            default: port = 16'($urandom);
          endcase
          wd = 8'($urandom);
          if (op == OP_WRITE && port == cmd_base + 16'(REG_CMD_STAT)) begin
            case ($urandom_range(0, 3))
              0:       wd = CMD_IDENTIFY;
              1:       wd = CMD_INIT_PARAMS;
              default: ;
            endcase
          end
          send_req(op, port, wd);
        end
        done += n;
      end
    end
  endtask

  initial begin : rsp_ready_gen
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 5);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_item_t got, want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.claimed, rsp_if.read_data, rsp_if.irq_raise};
      n_rsps++;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with nothing pending", n_rsps));
      end else begin
        want = pending_responses.pop_front();
        if (got.claimed !== want.claimed)
          report_mismatch($sformatf("response %0d claimed %b, expected %b",
                                    n_rsps, got.claimed, want.claimed));
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("response %0d read_data 0x%02h, expected 0x%02h",
                                    n_rsps, got.read_data, want.read_data));
        if (got.irq_raise !== want.irq_raise)
          report_mismatch($sformatf("response %0d irq_raise %b, expected %b",
                                    n_rsps, got.irq_raise, want.irq_raise));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request or response moved for %0d cycles", quiet);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] b;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_READ;
    req_if.port_address = '0;
    req_if.write_data   = '0;
    cmd_base            = COMMAND_BASE_RST;
    ctl_base            = CONTROL_BASE_RST;
    drv_present         = '0;
    drv_sectors[0]      = '0;
    drv_sectors[1]      = '0;
    tf[0]               = '0;
    tf[1]               = '0;
    act_drive           = 1'b0;
    cur_cmd             = '0;
    xstate              = XS_READY;
    id_pos              = 0;
    id_drive            = 1'b0;
    id_present          = 1'b0;
    id_sectors          = '0;
    dctl                = '0;
    dsel                = '0;
    idle_on             = 1'b1;
    mismatches          = 0;
    n_reqs              = 0;
    n_rsps              = 0;
    n_identify          = 0;
    n_id_bytes          = 0;
    n_aborts            = 0;
    n_settings          = 1;

    bringup = '{
      '{OP_READ,  16'h01F7, 8'h00, 1'b1, '{1'b1, ST_READY, 1'b0}},
      '{OP_READ,  16'h01F1, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F0, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F8, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_WRITE, 16'h01FD, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F5, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0}},
      '{OP_WRITE, 16'h01F7, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F1, 8'h00, 1'b1, '{1'b1, ERR_ABORT, 1'b0}},
      '{OP_READ,  16'h01F7, 8'h00, 1'b1, '{1'b1, ST_READY | ST_DRQ | ST_ERR, 1'b0}},
      '{OP_WRITE, 16'h01F7, CMD_INIT_PARAMS, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F1, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_WRITE, 16'h03F6, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h03F6, 8'h00, 1'b1, '{1'b1, 8'h0F, 1'b0}},
      '{OP_WRITE, 16'h03F7, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h03F7, 8'h00, 1'b1, '{1'b1, 8'h7F, 1'b0}},
      '{OP_READ,  16'h03F8, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_WRITE, 16'hFFFF, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_READ,  16'h0000, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_WRITE, 16'h01F6, 8'h10, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F6, 8'h00, 1'b1, '{1'b1, 8'h10, 1'b0}},
      '{OP_WRITE, 16'h01F7, CMD_IDENTIFY, 1'b1, '{1'b1, 8'h00, 1'b1}},
      '{OP_READ,  16'h01F0, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0}},
      '{OP_READ,  16'h01F7, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0}},
      '{OP_WRITE, 16'h01FE, 8'h5A, 1'b1, '{1'b0, 8'h00, 1'b0}},
      '{OP_WRITE, 16'h01FC, 8'hA5, 1'b0, '{1'b0, 8'h00, 1'b0}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (bringup[i])
      send_req(bringup[i].op, bringup[i].port, bringup[i].wd, bringup[i].typed, bringup[i].rsp);

    for (int ph = 0; ph < 4; ph++) begin
      drain_requests();
      case (ph)
        0: begin
          write_cfg(CFG_COMMAND_BASE, {12'($urandom), COMMAND_BASE_RST});
          write_cfg(CFG_CONTROL_BASE, {12'($urandom), CONTROL_BASE_RST});
          write_cfg(CFG_DRIVE0_PRESENT, 28'h0000001);
          write_cfg(CFG_DRIVE1_PRESENT, 28'hFFFFFFF);
          write_cfg(CFG_DRIVE0_SECTORS, 28'hFFFFFFF);
          write_cfg(CFG_DRIVE1_SECTORS, 28'd1007);
        end
        1: begin
          write_cfg(CFG_COMMAND_BASE, {12'hFFF, 16'hFFF2});
          write_cfg(CFG_CONTROL_BASE, {12'($urandom), 16'h0000});
          write_cfg(CFG_DRIVE0_PRESENT, 28'hFFFFFFE);
          write_cfg(CFG_DRIVE1_PRESENT, 28'h0000001);
          write_cfg(CFG_DRIVE0_SECTORS, 28'd0);
          write_cfg(CFG_DRIVE1_SECTORS, 28'hFFFFFFF);
        end
        2: begin
          write_cfg(CFG_COMMAND_BASE, {12'($urandom), 16'h0000});
          write_cfg(CFG_CONTROL_BASE, {12'h000, 16'hFFFE});
          write_cfg(CFG_DRIVE0_PRESENT, 28'h0000001);
          write_cfg(CFG_DRIVE1_PRESENT, 28'h0000000);
          write_cfg(CFG_DRIVE0_SECTORS, 28'd66059280 + 28'($urandom_range(0, 2015)));
          write_cfg(CFG_DRIVE1_SECTORS, 28'($urandom));
        end
        default: begin
          b = 16'($urandom_range(16'h0010, 16'hFFF0));
          write_cfg(CFG_COMMAND_BASE, {12'($urandom), b});
          write_cfg(CFG_CONTROL_BASE, {12'($urandom), b + 16'd13});
          write_cfg(CFG_DRIVE0_PRESENT, 28'($urandom));
          write_cfg(CFG_DRIVE1_PRESENT, 28'($urandom));
          write_cfg(CFG_DRIVE0_SECTORS, 28'($urandom));
          write_cfg(CFG_DRIVE1_SECTORS, 28'($urandom_range(0, 5000)));
        end
      endcase
      n_settings++;
      run_traffic((ph == 0) ? 1 : 8, ph == 0, 1'b0);
    end

    idle_on = 1'b0;
    run_traffic(8, 1'b0, 1'b1);
    drain_requests();

    $display("Covered %0d requests over %0d decode/drive settings, %0d identify commands,",
             n_reqs, n_settings, n_identify);
    $display("%0d identify bytes streamed, %0d aborted commands, %0d responses checked.",
             n_id_bytes, n_aborts, n_rsps);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
